[hw/rtl/chebyshev_series_evaluator_unit_assert.svh]
// Assertion macros shared by the Chebyshev series evaluator RTL.
`ifndef CHEBYSHEV_SERIES_EVALUATOR_UNIT_ASSERT_SVH
`define CHEBYSHEV_SERIES_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define CSE_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define CSE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cse_pkg.sv]
// Shared constants and types of the Chebyshev series evaluator.
`default_nettype none
package cse_pkg;

  localparam int NUM_TERMS   = 8;
  localparam int COEFF_COUNT = 8;

  localparam int X_W    = 16;
  localparam int T_W    = 17;
  localparam int COEF_W = 32;
  localparam int RES_W  = 32;
  localparam int XT_W   = X_W + T_W;
  localparam int PROD_W = COEF_W + T_W;
  localparam int ACC_W  = PROD_W + $clog2(COEFF_COUNT) + 1;

  localparam int APB_DW = 32;
  localparam int ADDR_W = $clog2(COEFF_COUNT) + 2;

  // T values are Q2.15, so 1.0 is 2^15.
  localparam int T_FRAC     = 15;
  localparam int T_ONE      = 32768;
  localparam int T_MAX      = 65535;
  localparam int T_MIN      = -65536;
  localparam int T_RND_SH   = 14;
  localparam int T_RND      = 8192;
  localparam int OUT_RND_SH = 15;
  localparam int OUT_RND    = 16384;

  typedef logic [COEFF_COUNT-1:0][COEF_W-1:0] coef_bank_t;

  typedef struct packed {
    logic signed [X_W-1:0]    x;
    logic signed [T_W-1:0]    t_cur;
    logic signed [T_W-1:0]    t_prev;
    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] prod;
  } cse_data_t;

endpackage
`default_nettype wire

[hw/rtl/cse_if.sv]
// Valid/ready channel interfaces for samples in and series results out.
`default_nettype none
interface cse_in_if import cse_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] sample_x;

  modport source (output valid, output sample_x, input ready);
  modport sink (input valid, input sample_x, output ready);
endinterface

interface cse_out_if import cse_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] approx_value;
  logic                    overflow;

  modport source (output valid, output approx_value, output overflow, input ready);
  modport sink (input valid, input approx_value, input overflow, output ready);
endinterface
`default_nettype wire

[hw/rtl/cse_regs.sv]
// APB coefficient register bank.
`default_nettype none
module cse_regs import cse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output coef_bank_t        coef_bank
);

  coef_bank_t                          coef_r;
  logic [$clog2(COEFF_COUNT)-1:0]      idx;

  assign idx       = paddr[ADDR_W-1:2];
  assign pready    = 1'b1;
  assign prdata    = coef_r[idx];
  assign coef_bank = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (psel && penable && pwrite) begin
      coef_r[idx] <= pwdata;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cse_stage.sv]
// One recurrence stage: forms the next T value, the current term product and the running sum.
`default_nettype none
module cse_stage import cse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic signed [COEF_W-1:0] coef,
  input  logic                     valid_i,
  input  cse_data_t                data_i,
  output logic                     valid_o,
  output cse_data_t                data_o
);

  localparam int TW_W = XT_W - T_RND_SH;
  localparam int DF_W = TW_W + 1;

  logic signed [XT_W-1:0]   xt_prod;
  logic signed [XT_W-1:0]   xt_rnd;
  logic signed [TW_W-1:0]   twice;
  logic signed [DF_W-1:0]   diff;
  logic signed [T_W-1:0]    t_next;
  logic signed [PROD_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_nxt;
  cse_data_t                data_nxt;
  logic                     valid_r;
  cse_data_t                data_r;

  always_comb begin
    xt_prod = XT_W'($signed(data_i.x)) * XT_W'($signed(data_i.t_cur));
    // Adding half an LSB and dropping the low bits rounds half up.
    xt_rnd  = xt_prod + XT_W'(T_RND);
    twice   = xt_rnd[XT_W-1:T_RND_SH];
    diff    = DF_W'(twice) - DF_W'($signed(data_i.t_prev));
    if (diff > DF_W'(T_MAX)) begin
      t_next = T_W'(T_MAX);
    end else if (diff < DF_W'(T_MIN)) begin
      t_next = T_W'(T_MIN);
    end else begin
      t_next = diff[T_W-1:0];
    end
    term    = PROD_W'(coef) * PROD_W'($signed(data_i.t_cur));
    acc_nxt = $signed(data_i.acc) + ACC_W'($signed(data_i.prod));

    data_nxt.x      = data_i.x;
    data_nxt.t_cur  = t_next;
    data_nxt.t_prev = data_i.t_cur;
    data_nxt.acc    = acc_nxt;
    data_nxt.prod   = term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule
`default_nettype wire

[hw/rtl/cse_out.sv]
// Final sum, rounding to Q16.16, saturation and the output register.
`default_nettype none
`include "chebyshev_series_evaluator_unit_assert.svh"
module cse_out import cse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    valid_i,
  input  cse_data_t               data_i,
  output logic                    out_valid,
  output logic signed [RES_W-1:0] approx_value,
  output logic                    overflow
);

  localparam int Q_W = ACC_W - OUT_RND_SH;

  logic                    sum_v_r;
  logic signed [ACC_W-1:0] sum_r;
  logic signed [ACC_W-1:0] sum_nxt;
  logic signed [ACC_W-1:0] rnd;
  logic [Q_W-1:0]          q;
  logic [Q_W-RES_W:0]      q_top;
  logic                    ovf_nxt;
  logic [RES_W-1:0]        res_nxt;
  logic                    out_valid_r;
  logic [RES_W-1:0]        approx_r;
  logic                    ovf_r;

  assign sum_nxt = $signed(data_i.acc) + ACC_W'($signed(data_i.prod));

  always_comb begin
    rnd   = sum_r + ACC_W'(OUT_RND);
    q     = rnd[ACC_W-1:OUT_RND_SH];
    // The value fits when every bit above the 32-bit sign agrees with it.
    q_top = q[Q_W-1:RES_W-1];
    ovf_nxt = !((&q_top) || (~|q_top));
    if (!ovf_nxt) begin
      res_nxt = q[RES_W-1:0];
    end else if (q[Q_W-1]) begin
      res_nxt = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(RES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sum_v_r     <= valid_i;
      out_valid_r <= sum_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r    <= sum_nxt;
      approx_r <= res_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign approx_value = approx_r;
  assign overflow     = ovf_r;

  `CSE_CHECK_NOW(a_ovf_saturated, out_valid_r && ovf_r, (approx_r == {1'b1, {(RES_W-1){1'b0}}}) || (approx_r == {1'b0, {(RES_W-1){1'b1}}}), "overflow set on an unsaturated word")
  `CSE_CHECK_NEXT(a_sum_moves_out, sum_v_r && adv, out_valid_r, "finished sum did not reach the output register")
  `CSE_CHECK_NEXT(a_no_extra_word, !sum_v_r && adv, !out_valid_r, "output word appeared without a sum")

endmodule
`default_nettype wire

[hw/rtl/chebyshev_series_evaluator_unit.sv]
// A sample passes the entry register, the recurrence stages, then the sum and output registers.
// Throughput: one sample per cycle while the result side takes words; one recurrence stage per term beyond the first.
// The whole pipeline advances together; it holds only while a result waits unread.
// Reset (synchronous, rst_n low) clears all valid bits and the coefficients to zero.
`default_nettype none
`include "chebyshev_series_evaluator_unit_assert.svh"
module chebyshev_series_evaluator_unit import cse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  cse_in_if.sink            in_ch,
  cse_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  coef_bank_t coef_bank;
  logic       adv;
  logic       out_valid;
  logic       entry_v_r;
  cse_data_t  entry_d_r;
  cse_data_t  entry_nxt;
  logic       pipe_v [NUM_TERMS];
  cse_data_t  pipe_d [NUM_TERMS];

  cse_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .coef_bank (coef_bank)
  );

  // The pipeline moves unless a result word sits unread.
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Entry stage: T_1 = x, T_0 = 1.0, first term is coeff_0 scaled by 2^15.
  always_comb begin
    entry_nxt.x      = in_ch.sample_x;
    entry_nxt.t_cur  = T_W'($signed(in_ch.sample_x));
    entry_nxt.t_prev = T_W'(T_ONE);
    entry_nxt.acc    = '0;
    entry_nxt.prod   = PROD_W'($signed(coef_bank[0])) <<< T_FRAC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_v_r <= 1'b0;
    end else if (adv) begin
      entry_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entry_d_r <= entry_nxt;
    end
  end

  assign pipe_v[0] = entry_v_r;
  assign pipe_d[0] = entry_d_r;

  for (genvar g = 1; g < NUM_TERMS; g++) begin : g_stage
    cse_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .coef    ($signed(coef_bank[g])),
      .valid_i (pipe_v[g-1]),
      .data_i  (pipe_d[g-1]),
      .valid_o (pipe_v[g]),
      .data_o  (pipe_d[g])
    );
  end

  cse_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .valid_i      (pipe_v[NUM_TERMS-1]),
    .data_i       (pipe_d[NUM_TERMS-1]),
    .out_valid    (out_valid),
    .approx_value (out_ch.approx_value),
    .overflow     (out_ch.overflow)
  );

  assign out_ch.valid = out_valid;

  `CSE_CHECK_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, entry_v_r, "accepted sample missing from the entry stage")
  `CSE_CHECK_NOW(a_ready_when_empty, !out_valid, in_ch.ready, "input held off with no word waiting")
  `CSE_CHECK_NEXT(a_word_held, out_valid && !out_ch.ready, out_valid && $stable(out_ch.approx_value), "waiting word changed")

endmodule
`default_nettype wire

[bench/chebyshev_series_evaluator_unit_tb.sv]
// Self-checking testbench for the Chebyshev series evaluator with its own series predictor.
`timescale 1ns / 1ps
`default_nettype none
module chebyshev_series_evaluator_unit_tb import cse_pkg::*; ();

  localparam int CLK_HALF    = 4;
  localparam int PIPE_DEPTH  = NUM_TERMS + 2;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 60;

  localparam logic [31:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COEF_MIN = 32'h8000_0000;
  localparam logic [31:0] COEF_ONE = 32'h0001_0000;

  typedef struct {
    logic signed [X_W-1:0]   x;
    logic signed [RES_W-1:0] approx_value;
    logic                    overflow;
  } series_word_t;

  // Holds a copy of the coefficient bank and the sums still owed by the block.
  class series_checker;
    logic signed [COEF_W-1:0] coeffs [COEFF_COUNT];
    series_word_t             pending_sums [$];
    int                       errors;
    int                       samples_seen;
    int                       words_checked;

    function new();
      foreach (coeffs[i]) coeffs[i] = '0;
      errors = 0;
      samples_seen = 0;
      words_checked = 0;
    endfunction

    function void report(string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function series_word_t predict_sum(logic signed [X_W-1:0] x);
      series_word_t w;
      longint       t_cur;
      longint       t_back1;
      longint       t_back2;
      longint       acc;
      longint       sum;
      int           k;
      t_back1 = 0;
      t_back2 = 0;
      acc = 0;
      for (k = 0; k < NUM_TERMS; k++) begin
        if (k == 0) begin
          t_cur = T_ONE;
        end else if (k == 1) begin
          t_cur = x;
        end else begin
          // Doubled product rounded half up to Q.15, then clamped to the Q2.15 range.
          t_cur = ((longint'(x) * t_back1 + 8192) >>> 14) - t_back2;
          if (t_cur > T_MAX) t_cur = T_MAX;
          if (t_cur < T_MIN) t_cur = T_MIN;
        end
        acc += longint'(coeffs[k]) * t_cur;
        t_back2 = t_back1;
        t_back1 = t_cur;
      end
      sum = (acc + 16384) >>> 15;
      w.x = x;
      w.overflow = 1'b0;
      if (sum > longint'(32'sh7FFF_FFFF)) begin
        sum = 32'sh7FFF_FFFF;
        w.overflow = 1'b1;
      end else if (sum < -longint'(64'sh8000_0000)) begin
        sum = -longint'(64'sh8000_0000);
        w.overflow = 1'b1;
      end
      w.approx_value = sum[RES_W-1:0];
      return w;
    endfunction

    function void note_sample(logic signed [X_W-1:0] x);
      pending_sums.insert(pending_sums.size(), predict_sum(x));
      samples_seen++;
    endfunction

    function void check_result(logic signed [RES_W-1:0] value, logic ovf);
      series_word_t w;
      words_checked++;
      if (pending_sums.size() == 0) begin
        report($sformatf("result word %0d / ovf %0b with no sample waiting", value, ovf));
      end else begin
        w = pending_sums.pop_front();
        if (value !== w.approx_value)
          report($sformatf("x=%0d approx_value %0d, predicted %0d", w.x, value,
                           w.approx_value));
        if (ovf !== w.overflow)
          report($sformatf("x=%0d overflow %0b, predicted %0b", w.x, ovf, w.overflow));
      end
    endfunction

    function void flush_check();
      series_word_t w;
      while (pending_sums.size() > 0) begin
        w = pending_sums.pop_front();
        report($sformatf("no result word for x=%0d", w.x));
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cse_in_if  in_ch ();
  cse_out_if out_ch ();

  series_checker sb = new();

  int send_gap_pct   = 0;
  int sink_stall_pct = 0;
  bit long_hold_req  = 1'b0;
  int settings_used  = 0;
  int cycle_count    = 0;

  chebyshev_series_evaluator_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_sample(in_ch.sample_x);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.approx_value, out_ch.overflow);
  end

  // Result side: random stalls, plus one long hold-off on request so the pipeline backs up.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic cfg_access(input bit is_write, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_coeff(input int idx);
    logic [31:0] rd;
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== sb.coeffs[idx])
      sb.report($sformatf("coeff_%0d reads %h, holds %h", idx, rd, sb.coeffs[idx]));
  endtask

  task automatic write_coeff(input int idx, input logic [31:0] val);
    logic [31:0] rd;
    cfg_access(1'b1, idx, val, rd);
    sb.coeffs[idx] = val;
    check_coeff(idx);
  endtask

  task automatic load_bank(input logic [31:0] bank [COEFF_COUNT]);
    for (int i = 0; i < COEFF_COUNT; i++) write_coeff(i, bank[i]);
    settings_used++;
  endtask

  task automatic load_uniform(input logic [31:0] val);
    logic [31:0] bank [COEFF_COUNT];
    foreach (bank[i]) bank[i] = val;
    load_bank(bank);
  endtask

  task automatic send_sample(input logic signed [X_W-1:0] x);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample_x <= x;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Every sample yields a word, so an empty queue means the pipeline has drained.
  // It first waits for a clock edge so the monitor has noted the last accepted sample.
  task automatic close_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_sums.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COEF_MAX;
      2:       return COEF_MIN;
      3:       return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [X_W-1:0] pick_sample();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return 16'sh0000;
        3:       return 16'sh0001;
        default: return 16'shFFFF;
      endcase
    end
    return X_W'($urandom);
  endfunction

  task automatic run_random(input int n, input int gap_pct, input int stall_pct);
    logic [31:0] bank [COEFF_COUNT];
    foreach (bank[i]) bank[i] = pick_coeff();
    load_bank(bank);
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    repeat (n) send_sample(pick_sample());
    close_phase();
  endtask

  initial begin
    logic [31:0] bank [COEFF_COUNT];
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.sample_x <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coefficients come out of reset as zero, so every sum is zero.
    for (int i = 0; i < COEFF_COUNT; i++) check_coeff(i);
    send_gap_pct   = 30;
    sink_stall_pct = 30;
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    close_phase();

    // Unit coefficients: the plain series at the ends and middle of the range.
    load_uniform(COEF_ONE);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    send_sample(16'sh4000);
    send_sample(-16'sh4000);
    send_sample(16'sh5555);
    close_phase();

    // Largest coefficients: the sum saturates high near x = 1 but not at x = -1.
    load_uniform(COEF_MAX);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh2000);
    close_phase();

    load_uniform(COEF_MIN);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sh2000);
    close_phase();

    // Only the constant term: the result is coeff_0 whatever the sample.
    foreach (bank[i]) bank[i] = '0;
    bank[0] = COEF_MIN;
    load_bank(bank);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    close_phase();

    run_random(300, 20, 20);
    long_hold_req = 1'b1;
    run_random(300, 5, 10);
    run_random(300, 50, 50);
    run_random(300, 10, 40);
    run_random(300, 40, 5);
    run_random(300, 0, 0);

    repeat (4 * PIPE_DEPTH) @(posedge clk);
    sb.flush_check();
    $display("Checked %0d result words for %0d samples across %0d coefficient settings.",
             sb.words_checked, sb.samples_seen, settings_used);
    $display("Run included sample extremes, saturated sums and a long result-side stall.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
